// File: sv/statement_completeness_detector_unit_macros.svh
// Assertion macros for the statement completeness detector checker.
`ifndef STATEMENT_COMPLETENESS_DETECTOR_UNIT_MACROS_SVH
`define STATEMENT_COMPLETENESS_DETECTOR_UNIT_MACROS_SVH

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scd checker: next-cycle property failed");

// Same-cycle invariant, sampled on clk, off while arst_n is low.
`define SCD_ASSERT_NOW(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scd checker: invariant failed");

`endif

// File: sv/scd_pkg.sv
// Package for the statement completeness detector: widths, codes, characters, counters.
`timescale 1ns / 1ps

package scd_pkg;

	localparam int CNT_W   = 8;
	localparam int DEPTH_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_CHAR  = 2'd0,
		CMD_EOL   = 2'd1,
		CMD_RESET = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		V_UNDECIDED  = 2'd0,
		V_COMPLETE   = 2'd1,
		V_INCOMPLETE = 2'd2,
		V_IGNORED    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] n);
		return (n == CNT_MAX) ? n : n + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_down(input logic [CNT_W-1:0] n);
		return (n == '0) ? n : n - CNT_W'(1);
	endfunction

endpackage

// File: sv/statement_completeness_detector_unit.sv
// Statement completeness detector: bracket depths, quote mode and line verdicts.
//
// Input channel (item_valid / item_stall): one word per cycle while item_stall
// is low, a command (character, end of line, reset depths) and a text byte.
// Output channel (result_valid / result_stall): one result word per input
// word: verdict, the three bracket depths and the quote mode.
// The result of an accepted word is registered and is shown from the cycle
// after it is accepted. One word per cycle while item_stall is low; all tracker
// state updates through short logic into the state and result registers.
// A finished result sits in the output register; item_stall is raised only
// while that register holds a result and result_stall is high, and drops in
// the cycle the result is taken, so the next word enters without a bubble.
// Reset (arst_n low) clears depths, quote mode, flags and result_valid.
// The reset-depths command keeps the quote mode and returns verdict complete.
`timescale 1ns / 1ps

module statement_completeness_detector_unit import scd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         command,
	input  logic [7:0]         character,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         verdict,
	output logic [DEPTH_W-1:0] paren_depth,
	output logic [DEPTH_W-1:0] bracket_depth,
	output logic [DEPTH_W-1:0] brace_depth,
	output logic [1:0]         quote_mode
);

	logic [CNT_W-1:0] paren_q, bracket_q, brace_q;
	quote_t           quote_q;
	logic             esc_q, pend_q, decided_q;

	logic [CNT_W-1:0] paren_n, bracket_n, brace_n;
	quote_t           quote_n;
	logic             esc_n, pend_n, decided_n;
	verdict_t         verdict_n;

	logic             valid_q;
	verdict_t         verdict_q;
	logic [CNT_W-1:0] paren_out_q, bracket_out_q, brace_out_q;
	quote_t           quote_out_q;

	logic accept;
	logic plain;
	logic all_zero;
	logic blank;

	assign item_stall = valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	assign plain    = (quote_q == Q_NONE);
	assign all_zero = (paren_q == '0) && (bracket_q == '0) && (brace_q == '0);
	assign blank    = (character inside {[CH_TAB:CH_CR], CH_SPACE});

	always_comb begin
		paren_n   = paren_q;
		bracket_n = bracket_q;
		brace_n   = brace_q;
		quote_n   = quote_q;
		esc_n     = esc_q;
		pend_n    = pend_q;
		decided_n = decided_q;
		verdict_n = V_UNDECIDED;
		case (command)
			CMD_CHAR: begin
				if (decided_q) begin
					verdict_n = V_IGNORED;
				end else if (pend_q && character == CH_HASH) begin
					// comment after a finished statement
					decided_n = 1'b1;
					verdict_n = V_COMPLETE;
				end else begin
					if (pend_q && !blank)
						pend_n = 1'b0;
					esc_n = 1'b0;
					case (character)
						CH_LPAREN:   if (plain) paren_n = cnt_up(paren_q);
						CH_RPAREN:   if (plain) paren_n = cnt_down(paren_q);
						CH_LBRACKET: if (plain) bracket_n = cnt_up(bracket_q);
						CH_RBRACKET: if (plain) bracket_n = cnt_down(bracket_q);
						CH_LBRACE:   if (plain) brace_n = cnt_up(brace_q);
						CH_RBRACE: begin
							if (plain) begin
								brace_n = cnt_down(brace_q);
								if (paren_q == '0 && bracket_q == '0 && brace_n == '0)
									pend_n = 1'b1;
							end
						end
						// semicolon counts even inside quotes
						CH_SEMI: if (all_zero) pend_n = 1'b1;
						CH_SQUOTE: begin
							if (quote_q == Q_NONE)
								quote_n = Q_SINGLE;
							else if (quote_q == Q_SINGLE && !esc_q)
								quote_n = Q_NONE;
						end
						CH_DQUOTE: begin
							if (quote_q == Q_NONE)
								quote_n = Q_DOUBLE;
							else if (quote_q == Q_DOUBLE && !esc_q)
								quote_n = Q_NONE;
						end
						CH_BACKSLASH: esc_n = ~esc_q;
						CH_HASH: begin
							if (plain) begin
								decided_n = 1'b1;
								verdict_n = V_INCOMPLETE;
							end
						end
						default: ;
					endcase
				end
			end
			CMD_EOL: begin
				if (decided_q)
					verdict_n = V_IGNORED;
				else if (pend_q)
					verdict_n = V_COMPLETE;
				else
					verdict_n = V_INCOMPLETE;
				esc_n     = 1'b0;
				pend_n    = 1'b0;
				decided_n = 1'b0;
			end
			CMD_RESET: begin
				paren_n   = '0;
				bracket_n = '0;
				brace_n   = '0;
				esc_n     = 1'b0;
				pend_n    = 1'b0;
				decided_n = 1'b0;
				verdict_n = V_COMPLETE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paren_q   <= '0;
			bracket_q <= '0;
			brace_q   <= '0;
			quote_q   <= Q_NONE;
			esc_q     <= 1'b0;
			pend_q    <= 1'b0;
			decided_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				paren_q   <= paren_n;
				bracket_q <= bracket_n;
				brace_q   <= brace_n;
				quote_q   <= quote_n;
				esc_q     <= esc_n;
				pend_q    <= pend_n;
				decided_q <= decided_n;
				valid_q   <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			verdict_q     <= verdict_n;
			paren_out_q   <= paren_n;
			bracket_out_q <= bracket_n;
			brace_out_q   <= brace_n;
			quote_out_q   <= quote_n;
		end
	end

	assign result_valid  = valid_q;
	assign verdict       = verdict_q;
	assign paren_depth   = DEPTH_W'(paren_out_q);
	assign bracket_depth = DEPTH_W'(bracket_out_q);
	assign brace_depth   = DEPTH_W'(brace_out_q);
	assign quote_mode    = quote_out_q;

endmodule

// File: sv/scd_checker.sv
// Port-level checker for the statement completeness detector, with its bind.
`timescale 1ns / 1ps
`include "statement_completeness_detector_unit_macros.svh"

module scd_checker import scd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic [1:0]         command,
	input logic [7:0]         character,
	input logic               result_valid,
	input logic               result_stall,
	input logic [1:0]         verdict,
	input logic [DEPTH_W-1:0] paren_depth,
	input logic [DEPTH_W-1:0] bracket_depth,
	input logic [DEPTH_W-1:0] brace_depth,
	input logic [1:0]         quote_mode
);

	logic take;
	assign take = item_valid & ~item_stall;

	// a held result stays up
	`SCD_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

	// depth reset shows up as complete with all depths at zero
	`SCD_ASSERT_NEXT(a_reset_cmd, take && command == CMD_RESET,
		result_valid && verdict == V_COMPLETE && paren_depth == '0 &&
		bracket_depth == '0 && brace_depth == '0)

	// an end of line always yields a decision
	`SCD_ASSERT_NEXT(a_eol_decides, take && command == CMD_EOL,
		result_valid && verdict != V_UNDECIDED)

	// quote mode never shows the unused code
	`SCD_ASSERT_NOW(a_quote_code, !result_valid || quote_mode != 2'd3)

endmodule

bind statement_completeness_detector_unit scd_checker u_scd_checker (.*);
